/* src/midi_event_serializer_assert.svh */
// Assertion macros for the MIDI event serializer.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef MIDI_EVENT_SERIALIZER_ASSERT_SVH
`define MIDI_EVENT_SERIALIZER_ASSERT_SVH

// check on every clock edge outside reset
`define MES_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("serializer assertion failed");

// check on every clock edge, reset included
`define MES_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("serializer assertion failed in reset");

`endif

/* src/mes_pkg.sv */
// Package for the MIDI event serializer: payload types, event codes, wire constants.
// No dependencies.
`timescale 1ns / 1ps

package mes_pkg;

    localparam int CHUNK_BYTES_DEF = 12;
    localparam int QUEUE_DEPTH     = 2;
    localparam int SRC_BYTES       = 12;
    localparam int HALF_BYTES      = 6;
    localparam int FIXED_MAX_BYTES = 12;

    localparam logic [4:0] ACT_NOTE      = 5'd1;
    localparam logic [4:0] ACT_KEYON     = 5'd2;
    localparam logic [4:0] ACT_KEYOFF    = 5'd3;
    localparam logic [4:0] ACT_POLYTOUCH = 5'd4;
    localparam logic [4:0] ACT_CTRL      = 5'd5;
    localparam logic [4:0] ACT_PROG      = 5'd6;
    localparam logic [4:0] ACT_CHANPRESS = 5'd7;
    localparam logic [4:0] ACT_BEND      = 5'd8;
    localparam logic [4:0] ACT_SONGPOS   = 5'd9;
    localparam logic [4:0] ACT_SONGSEL   = 5'd10;
    localparam logic [4:0] ACT_CLOCK     = 5'd11;
    localparam logic [4:0] ACT_START     = 5'd12;
    localparam logic [4:0] ACT_CONTINUE  = 5'd13;
    localparam logic [4:0] ACT_STOP      = 5'd14;
    localparam logic [4:0] ACT_TUNE      = 5'd15;
    localparam logic [4:0] ACT_SENSE     = 5'd16;
    localparam logic [4:0] ACT_RESET     = 5'd17;
    localparam logic [4:0] ACT_SYSEX     = 5'd18;
    localparam logic [4:0] ACT_STREAM    = 5'd19;
    localparam logic [4:0] ACT_QFRAME    = 5'd20;
    localparam logic [4:0] ACT_CTRL14    = 5'd21;
    localparam logic [4:0] ACT_NRPN      = 5'd22;
    localparam logic [4:0] ACT_RPN       = 5'd23;

    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_POLY     = 4'hA;
    localparam logic [3:0] NIB_CTRL     = 4'hB;
    localparam logic [3:0] NIB_PROG     = 4'hC;
    localparam logic [3:0] NIB_CHPRESS  = 4'hD;
    localparam logic [3:0] NIB_BEND     = 4'hE;

    localparam logic [7:0] ST_SYSEX   = 8'hF0;
    localparam logic [7:0] ST_QFRAME  = 8'hF1;
    localparam logic [7:0] ST_SONGPOS = 8'hF2;
    localparam logic [7:0] ST_SONGSEL = 8'hF3;
    localparam logic [7:0] ST_TUNE    = 8'hF6;
    localparam logic [7:0] ST_EOX     = 8'hF7;
    localparam logic [7:0] ST_CLOCK   = 8'hF8;
    localparam logic [7:0] ST_START   = 8'hFA;
    localparam logic [7:0] ST_CONT    = 8'hFB;
    localparam logic [7:0] ST_STOP    = 8'hFC;
    localparam logic [7:0] ST_SENSE   = 8'hFE;
    localparam logic [7:0] ST_RESET   = 8'hFF;

    localparam logic [7:0] CC_NRPN_MSB  = 8'd99;
    localparam logic [7:0] CC_NRPN_LSB  = 8'd98;
    localparam logic [7:0] CC_RPN_MSB   = 8'd101;
    localparam logic [7:0] CC_RPN_LSB   = 8'd100;
    localparam logic [7:0] CC_DATA_MSB  = 8'd6;
    localparam logic [7:0] CC_DATA_LSB  = 8'd38;
    localparam logic [7:0] CC14_LSB_OFS = 8'd32;

    typedef struct packed {
        logic [4:0]  action;
        logic [3:0]  channel;
        logic [6:0]  data_one;
        logic [6:0]  data_two;
        logic [13:0] param_number;
        logic [13:0] param_value;
        logic [47:0] chunk_low;
        logic [47:0] chunk_high;
        logic        chunk_final;
        logic [3:0]  final_count;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } result_t;

    function automatic int max_bytes(input int chunk_bytes);
        max_bytes = (chunk_bytes + 1 > FIXED_MAX_BYTES) ? chunk_bytes + 1 : FIXED_MAX_BYTES;
    endfunction

endpackage

/* src/midi_event_serializer.sv */
// MIDI event serializer top level: front classifier, job queue, byte back end.
// Depends on mes_pkg, mes_front, mes_queue, mes_back and the assertion header.
//
// Usage:
// Input side is a queue write port: drive item and push; a transaction
// completes at a clock edge with push high and full low. Each item is one
// MIDI event and gives 0 to max(CHUNK_BYTES+1, 12) wire bytes (13 by default).
// Result side is a queue read port: while empty is low, result holds the
// oldest byte, with last_byte set on the final byte of its event; pop takes it.
// The first byte of an event passes through the queue, then the result register.
// One byte per cycle goes through the single result register while pop keeps
// taking bytes; the front takes the next event while the back end still works,
// up to two events queued.
// Events that give no bytes are accepted at the input and give nothing at the output.
// When pop stays low, the result register holds its byte, the queue fills and
// full rises; nothing is dropped.
// Reset clears the queue, the result valid flag and the open-chunk flag.
`timescale 1ns / 1ps

module midi_event_serializer
    import mes_pkg::*;
#(
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  item_t   item,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

`include "midi_event_serializer_assert.svh"

    localparam int MAX_BYTES = max_bytes(CHUNK_BYTES);
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int JOB_W     = MAX_BYTES * 8 + CNT_W;

    logic                      accept;
    logic                      q_push;
    logic                      q_pop;
    logic                      q_valid;
    logic                      in_progress;
    logic [MAX_BYTES-1:0][7:0] job_bytes;
    logic [CNT_W-1:0]          job_count;
    logic [MAX_BYTES-1:0][7:0] head_bytes;
    logic [CNT_W-1:0]          head_count;
    logic [JOB_W-1:0]          q_wr_data;
    logic [JOB_W-1:0]          q_rd_data;

    assign accept    = push && !full;
    assign q_wr_data = {job_count, job_bytes};
    assign {head_count, head_bytes} = q_rd_data;

    mes_front #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .MAX_BYTES   (MAX_BYTES),
        .CNT_W       (CNT_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .job_push    (q_push),
        .job_bytes   (job_bytes),
        .job_count   (job_count),
        .in_progress (in_progress)
    );

    mes_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .valid   (q_valid),
        .full    (full)
    );

    mes_back #(
        .MAX_BYTES (MAX_BYTES),
        .CNT_W     (CNT_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_bytes (head_bytes),
        .head_count (head_count),
        .head_pop   (q_pop),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

    `MES_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (empty && !q_valid && !in_progress))
    `MES_ASSERT(a_job_reaches_output, (q_valid && empty) |=> !empty)
    `MES_ASSERT(a_push_fills_queue, q_push |=> q_valid)
    `MES_ASSERT(a_flag_on_chunk_only, !accept |=> $stable(in_progress))

endmodule

/* src/mes_front.sv */
// Front part: classifies one event into its list of wire bytes and a byte count.
// Holds the open-chunk flag. Depends on mes_pkg.
`timescale 1ns / 1ps

module mes_front
    import mes_pkg::*;
#(
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
    parameter int MAX_BYTES   = max_bytes(CHUNK_BYTES_DEF),
    parameter int CNT_W       = $clog2(max_bytes(CHUNK_BYTES_DEF) + 1)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  item_t                      item,
    output logic                       job_push,
    output logic [MAX_BYTES-1:0][7:0]  job_bytes,
    output logic [CNT_W-1:0]           job_count,
    output logic                       in_progress
);

    localparam logic [CNT_W-1:0] CB_FULL = CNT_W'(CHUNK_BYTES);
    localparam logic [CNT_W-1:0] CB_LAST = CNT_W'(CHUNK_BYTES - 1);

    logic                      flag_reg;
    logic                      flag_next;
    logic [MAX_BYTES-1:0][7:0] cb;
    logic [MAX_BYTES-1:0][7:0] ch_b;
    logic [CNT_W-1:0]          ch_cnt;
    logic [CNT_W-1:0]          fc;
    logic [CNT_W-1:0]          n;
    logic                      is_sysex;
    logic                      is_chunk;
    logic                      off;
    logic                      eox;
    logic [7:0]                cc_st;
    logic [7:0]                d1;
    logic [7:0]                d2;

    genvar k;
    generate
        for (k = 0; k < MAX_BYTES; k++) begin : g_cb
            if (k < HALF_BYTES) begin : g_lo
                assign cb[k] = item.chunk_low[8*k +: 8];
            end
            else if (k < SRC_BYTES) begin : g_hi
                assign cb[k] = item.chunk_high[8*(k-HALF_BYTES) +: 8];
            end
            else begin : g_zero
                assign cb[k] = 8'h00;
            end
        end
    endgenerate

    assign is_sysex = (item.action == ACT_SYSEX);
    assign is_chunk = is_sysex || (item.action == ACT_STREAM);
    assign off      = is_sysex && !flag_reg;
    assign eox      = is_sysex && item.chunk_final;
    assign fc       = CNT_W'(item.final_count);
    assign n        = item.chunk_final ? ((fc > CB_LAST) ? CB_LAST : fc) : CB_FULL;

    always_comb
    begin
        ch_b = '0;
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            if (off && i == 0)
            begin
                ch_b[i] = ST_SYSEX;
            end
            else if (CNT_W'(off ? i - 1 : i) < n)
            begin
                ch_b[i] = cb[off ? i - 1 : i];
            end
            else if (CNT_W'(off ? i - 1 : i) == n && eox)
            begin
                ch_b[i] = ST_EOX;
            end
        end
        ch_cnt = CNT_W'(off) + n + CNT_W'(eox);
    end

    assign cc_st = {NIB_CTRL, item.channel};
    assign d1    = {1'b0, item.data_one};
    assign d2    = {1'b0, item.data_two};

    always_comb
    begin
        job_bytes = '0;
        job_count = '0;
        unique case (item.action)
            ACT_NOTE, ACT_KEYON:
            begin
                job_bytes[0] = {NIB_NOTE_ON, item.channel};
                job_bytes[1] = d1;
                job_bytes[2] = d2;
                job_count    = CNT_W'(3);
            end
            ACT_KEYOFF:
            begin
                job_bytes[0] = {NIB_NOTE_OFF, item.channel};
                job_bytes[1] = d1;
                job_bytes[2] = d2;
                job_count    = CNT_W'(3);
            end
            ACT_POLYTOUCH:
            begin
                job_bytes[0] = {NIB_POLY, item.channel};
                job_bytes[1] = d1;
                job_bytes[2] = d2;
                job_count    = CNT_W'(3);
            end
            ACT_CTRL:
            begin
                job_bytes[0] = cc_st;
                job_bytes[1] = d1;
                job_bytes[2] = d2;
                job_count    = CNT_W'(3);
            end
            ACT_PROG:
            begin
                job_bytes[0] = {NIB_PROG, item.channel};
                job_bytes[1] = d1;
                job_count    = CNT_W'(2);
            end
            ACT_CHANPRESS:
            begin
                job_bytes[0] = {NIB_CHPRESS, item.channel};
                job_bytes[1] = d1;
                job_count    = CNT_W'(2);
            end
            ACT_BEND:
            begin
                job_bytes[0] = {NIB_BEND, item.channel};
                job_bytes[1] = d1;
                job_bytes[2] = d2;
                job_count    = CNT_W'(3);
            end
            ACT_SONGPOS:
            begin
                job_bytes[0] = ST_SONGPOS;
                job_bytes[1] = d1;
                job_bytes[2] = d2;
                job_count    = CNT_W'(3);
            end
            ACT_SONGSEL:
            begin
                job_bytes[0] = ST_SONGSEL;
                job_bytes[1] = d1;
                job_count    = CNT_W'(2);
            end
            ACT_CLOCK:
            begin
                job_bytes[0] = ST_CLOCK;
                job_count    = CNT_W'(1);
            end
            ACT_START:
            begin
                job_bytes[0] = ST_START;
                job_count    = CNT_W'(1);
            end
            ACT_CONTINUE:
            begin
                job_bytes[0] = ST_CONT;
                job_count    = CNT_W'(1);
            end
            ACT_STOP:
            begin
                job_bytes[0] = ST_STOP;
                job_count    = CNT_W'(1);
            end
            ACT_TUNE:
            begin
                job_bytes[0] = ST_TUNE;
                job_count    = CNT_W'(1);
            end
            ACT_SENSE:
            begin
                job_bytes[0] = ST_SENSE;
                job_count    = CNT_W'(1);
            end
            ACT_RESET:
            begin
                job_bytes[0] = ST_RESET;
                job_count    = CNT_W'(1);
            end
            ACT_SYSEX, ACT_STREAM:
            begin
                job_bytes = ch_b;
                job_count = ch_cnt;
            end
            ACT_QFRAME:
            begin
                job_bytes[0] = ST_QFRAME;
                job_bytes[1] = {1'b0, item.data_one[2:0], item.data_two[3:0]};
                job_count    = CNT_W'(2);
            end
            ACT_CTRL14:
            begin
                job_bytes[0] = cc_st;
                job_bytes[1] = 8'(item.param_number[4:0]);
                job_bytes[2] = {1'b0, item.param_value[13:7]};
                job_bytes[3] = cc_st;
                job_bytes[4] = 8'(item.param_number[4:0]) + CC14_LSB_OFS;
                job_bytes[5] = {1'b0, item.param_value[6:0]};
                job_count    = CNT_W'(6);
            end
            ACT_NRPN, ACT_RPN:
            begin
                job_bytes[0]  = cc_st;
                job_bytes[1]  = (item.action == ACT_NRPN) ? CC_NRPN_MSB : CC_RPN_MSB;
                job_bytes[2]  = {1'b0, item.param_number[13:7]};
                job_bytes[3]  = cc_st;
                job_bytes[4]  = (item.action == ACT_NRPN) ? CC_NRPN_LSB : CC_RPN_LSB;
                job_bytes[5]  = {1'b0, item.param_number[6:0]};
                job_bytes[6]  = cc_st;
                job_bytes[7]  = CC_DATA_MSB;
                job_bytes[8]  = {1'b0, item.param_value[13:7]};
                job_bytes[9]  = cc_st;
                job_bytes[10] = CC_DATA_LSB;
                job_bytes[11] = {1'b0, item.param_value[6:0]};
                job_count     = CNT_W'(12);
            end
            default:
            begin
                job_count = '0;
            end
        endcase
    end

    assign job_push    = accept && (job_count != '0);
    assign flag_next   = (accept && is_chunk) ? !item.chunk_final : flag_reg;
    assign in_progress = flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

endmodule

/* src/mes_queue.sv */
// Short job queue between the front and back parts.
// Generic width and depth; no package dependency beyond the file set.
`timescale 1ns / 1ps

module mes_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             valid,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == CNT_FULL);
    assign valid   = (cnt_reg != '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* src/mes_back.sv */
// Back part: walks the head job one byte per cycle into the result register
// while that register is free or being popped. Depends on mes_pkg.
`timescale 1ns / 1ps

module mes_back
    import mes_pkg::*;
#(
    parameter int MAX_BYTES = max_bytes(CHUNK_BYTES_DEF),
    parameter int CNT_W     = $clog2(max_bytes(CHUNK_BYTES_DEF) + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      head_valid,
    input  logic [MAX_BYTES-1:0][7:0] head_bytes,
    input  logic [CNT_W-1:0]          head_count,
    output logic                      head_pop,
    input  logic                      pop,
    output logic                      empty,
    output result_t                   result
);

    localparam int IDX_W = $clog2(MAX_BYTES);

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_reg;
    logic             load;
    logic             is_last;

    assign load     = head_valid && (!out_valid_reg || pop);
    assign is_last  = (CNT_W'(idx_reg) == head_count - 1'b1);
    assign head_pop = load && is_last;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = is_last ? '0 : idx_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.out_byte  <= head_bytes[idx_reg];
            out_reg.last_byte <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
